@@ hw/rtl/segment_address_resolver_core_macros.svh @@
// Assertion macros for the segment address resolver
`ifndef SEGMENT_ADDRESS_RESOLVER_CORE_MACROS_SVH
`define SEGMENT_ADDRESS_RESOLVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SAR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define SAR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define SAR_ASSERT(label, prop)
`define SAR_ASSERT_NEXT(label, pre, post)
`endif

`endif

@@ hw/rtl/sar_pkg.sv @@
// Types and constants for the segment address resolver
package sar_pkg;

	localparam int NUM_SEGMENTS_DEFAULT = 16;
	localparam int ADDR_W = 32;
	localparam int SEG_W = 4;
	localparam int OFFSET_W = 24;

	localparam logic [ADDR_W-1:0] SEG_LOW_LIMIT = 32'h0300_0000;
	localparam logic [ADDR_W-1:0] OFFSET_MASK = 32'h00FF_FFFF;
	localparam logic [ADDR_W-1:0] WINDOW_LOW = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] WINDOW_HIGH = 32'h8300_0000;
	localparam logic [SEG_W-1:0] SEG_FIELD_MASK = 4'hF;

	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BELOW = 2'd1,
		ST_ABNORMAL = 2'd2,
		ST_WRITE = 2'd3
	} status_t;

	typedef struct packed {
		op_t opcode;
		logic [ADDR_W-1:0] seg_address;
		logic [SEG_W-1:0] entry_index;
		logic [ADDR_W-1:0] entry_base;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] phys_address;
		status_t status;
		logic [ADDR_W-1:0] resolved_total;
		logic [ADDR_W-1:0] abnormal_total;
	} rsp_t;

endpackage

@@ hw/rtl/segment_address_resolver_core.sv @@
// Segment address resolver: segment table, address translation and counters
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | sar_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready  | sar_pkg::rsp_t
//
// One word per cycle unless rsp stalls; s1 registers the word, s2 its result.
// The table read, one 32-bit add and the window compares sit between the
// input stage and the result stage; table and counters update as a word leaves s1.
// Reset clears the segment table, both counters and both stage valids.
// A stalled result holds s2; s1 still takes a word while s2 is free or drains.
`include "segment_address_resolver_core_macros.svh"

module segment_address_resolver_core #(
	parameter int NUM_SEGMENTS = sar_pkg::NUM_SEGMENTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sar_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sar_pkg::rsp_t rsp
);

	localparam int IdxW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
	localparam int CmpW = sar_pkg::SEG_W + 1;

	logic valid_s1;
	sar_pkg::req_t req_s1;
	logic valid_s2;
	sar_pkg::rsp_t rsp_s2;

	logic [sar_pkg::ADDR_W-1:0] table_q [NUM_SEGMENTS];
	logic [sar_pkg::ADDR_W-1:0] resolved_q;
	logic [sar_pkg::ADDR_W-1:0] abnormal_q;

	logic advance;
	logic fire;
	logic [sar_pkg::SEG_W-1:0] seg;
	logic seg_in_range;
	logic wr_in_range;
	logic [sar_pkg::ADDR_W-1:0] base;
	logic [sar_pkg::ADDR_W-1:0] phys;
	logic res_inc;
	logic abn_inc;
	logic do_write;
	logic [sar_pkg::ADDR_W-1:0] resolved_d;
	logic [sar_pkg::ADDR_W-1:0] abnormal_d;
	sar_pkg::status_t status;
	sar_pkg::rsp_t rsp_d;

	assign advance = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign fire = advance && valid_s1;

	assign seg = req_s1.seg_address[sar_pkg::ADDR_W-5 -: sar_pkg::SEG_W]
		& sar_pkg::SEG_FIELD_MASK;
	assign seg_in_range = {1'b0, seg} < CmpW'(NUM_SEGMENTS);
	assign wr_in_range = {1'b0, req_s1.entry_index} < CmpW'(NUM_SEGMENTS);
	assign base = seg_in_range ? table_q[seg[IdxW-1:0]] : '0;

	always_comb begin
		phys = '0;
		status = sar_pkg::ST_OK;
		res_inc = 1'b0;
		abn_inc = 1'b0;
		do_write = 1'b0;
		unique case (req_s1.opcode)
			sar_pkg::OP_TRANSLATE: begin
				if (req_s1.seg_address[sar_pkg::ADDR_W-1 -: sar_pkg::SEG_W] == '0) begin
					res_inc = 1'b1;
					if (req_s1.seg_address < sar_pkg::SEG_LOW_LIMIT) begin
						phys = req_s1.seg_address + sar_pkg::WINDOW_LOW;
						status = sar_pkg::ST_BELOW;
					end else begin
						phys = base + (req_s1.seg_address & sar_pkg::OFFSET_MASK);
					end
				end else begin
					phys = req_s1.seg_address;
				end
				if (phys < sar_pkg::WINDOW_LOW || phys >= sar_pkg::WINDOW_HIGH) begin
					abn_inc = 1'b1;
					status = sar_pkg::ST_ABNORMAL;
				end
			end
			sar_pkg::OP_WRITE: begin
				status = sar_pkg::ST_WRITE;
				do_write = wr_in_range;
			end
			default: begin
				status = sar_pkg::ST_OK;
			end
		endcase
	end

	assign resolved_d = resolved_q + sar_pkg::ADDR_W'(res_inc);
	assign abnormal_d = abnormal_q + sar_pkg::ADDR_W'(abn_inc);

	always_comb begin
		rsp_d.phys_address = phys;
		rsp_d.status = status;
		rsp_d.resolved_total = resolved_d;
		rsp_d.abnormal_total = abnormal_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			resolved_q <= '0;
			abnormal_q <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				resolved_q <= resolved_d;
				abnormal_q <= abnormal_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEGMENTS; i++) begin
				table_q[i] <= '0;
			end
		end else if (fire && do_write) begin
			table_q[req_s1.entry_index[IdxW-1:0]] <= req_s1.entry_base;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

	`SAR_ASSERT_NEXT(a_counters_hold, !fire,
		$stable(resolved_q) && $stable(abnormal_q))
	`SAR_ASSERT(a_resolved_step,
		(resolved_q == $past(resolved_q)) || (resolved_q == $past(resolved_q) + 32'd1))
	`SAR_ASSERT(a_below_in_window,
		(valid_s2 && rsp_s2.status == sar_pkg::ST_BELOW) |->
		(rsp_s2.phys_address >= sar_pkg::WINDOW_LOW &&
		rsp_s2.phys_address < sar_pkg::WINDOW_HIGH))
	`SAR_ASSERT(a_write_zero_phys,
		(valid_s2 && rsp_s2.status == sar_pkg::ST_WRITE) |-> (rsp_s2.phys_address == '0))

endmodule
